// ----- sv/lcdseq_pkg.sv -----
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Shared types, register map and constants for the LCD write sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  // request kinds
  localparam logic [1:0] KIND_INIT   = 2'd0;
  localparam logic [1:0] KIND_CMD    = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;
  localparam logic [1:0] KIND_CURSOR = 2'd3;

  // register indexes (byte address 4*index)
  localparam logic [1:0] REG_RS_SETUP = 2'd0;
  localparam logic [1:0] REG_EN_PULSE = 2'd1;
  localparam logic [1:0] REG_SETTLE   = 2'd2;
  localparam logic [1:0] REG_LONG_CMD = 2'd3;

  // register reset values
  localparam logic [9:0]  RST_RS_SETUP = 10'd1;
  localparam logic [9:0]  RST_EN_PULSE = 10'd5;
  localparam logic [13:0] RST_SETTLE   = 14'd50;
  localparam logic [13:0] RST_LONG_CMD = 14'd2000;

  // display commands
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

  localparam logic [3:0] NIB_WAKE = 4'h3;
  localparam logic [3:0] NIB_4BIT = 4'h2;

  // fixed waits in microseconds
  localparam logic [15:0] POWER_UP_US     = 16'd50000;
  localparam logic [12:0] FIRST_NIBBLE_US = 13'd5000;
  localparam logic [12:0] LATER_NIBBLE_US = 13'd200;
  localparam logic [15:0] WAIT_MAX        = 16'hFFFF;

  localparam logic [2:0] BOOT_LAST = 3'd4;
  localparam logic [2:0] NIB_LAST  = 3'd7;
  localparam logic [2:0] SUB_LAST  = 3'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [1:0] line;
    logic [6:0] column;
  } in_item_t;

  typedef struct packed {
    logic        rs_level;
    logic        enable_level;
    logic [3:0]  data_nibble;
    logic [15:0] wait_us;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [9:0]  rs_setup_us;
    logic [9:0]  enable_pulse_us;
    logic [13:0] byte_settle_us;
    logic [13:0] long_command_us;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] val;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POWER,
    ST_NIB,
    ST_BYTE
  } seq_state_t;

  function automatic logic [7:0] boot_cmd(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = CMD_FUNC_SET;
      3'd1:    c = CMD_DISP_OFF;
      3'd2:    c = CMD_CLEAR;
      3'd3:    c = CMD_ENTRY;
      default: c = CMD_DISP_ON;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] sat16(input logic [16:0] s);
    return s[16] ? WAIT_MAX : s[15:0];
  endfunction

endpackage

// ----- sv/lcdseq_front.sv -----
// ----------------------------------------------------------------------------
// lcdseq_front
// Classifies a request into a job: init flag, RS level and byte to send.
// ----------------------------------------------------------------------------
module lcdseq_front (
  input  lcdseq_pkg::in_item_t in_data,
  output lcdseq_pkg::job_t     job
);
  import lcdseq_pkg::*;

  logic [1:0] line_m1;
  logic [6:0] col_m1;
  logic [6:0] addr;

  // (line-1)*64 + (column-1), wrapped to 7 bits
  assign line_m1 = in_data.line - 2'd1;
  assign col_m1  = in_data.column - 7'd1;
  assign addr    = {line_m1[0], 6'd0} + col_m1;

  always_comb begin
    job = '0;
    unique case (in_data.kind)
      KIND_INIT: begin
        job.is_init = 1'b1;
      end
      KIND_CMD: begin
        job.val = in_data.value;
      end
      KIND_DATA: begin
        job.rs  = 1'b1;
        job.val = in_data.value;
      end
      KIND_CURSOR: begin
        job.val = CMD_SET_DDRAM | {1'b0, addr};
      end
      default: job = '0;
    endcase
  end

endmodule

// ----- sv/lcdseq_queue.sv -----
// ----------------------------------------------------------------------------
// lcdseq_queue
// Small job queue between front and back.
// ----------------------------------------------------------------------------
module lcdseq_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  lcdseq_pkg::job_t wr_job,
  output logic             q_full,
  input  logic             rd_en,
  output lcdseq_pkg::job_t rd_job,
  output logic             q_valid
);
  import lcdseq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == CW'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign rd_job  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

endmodule

// ----- sv/lcdseq_back.sv -----
// ----------------------------------------------------------------------------
// lcdseq_back
// Step sequencer: turns jobs into pin steps in an output register, one
// per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module lcdseq_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lcdseq_pkg::cfg_t      cfg,
  input  logic                  job_valid,
  input  lcdseq_pkg::job_t      job,
  output logic                  job_pop,
  input  logic                  pop,
  output logic                  empty,
  output lcdseq_pkg::out_item_t out_data
);
  import lcdseq_pkg::*;

  seq_state_t  state_r, state_nxt;
  logic [2:0]  nib_r, nib_nxt;
  logic [2:0]  sub_r, sub_nxt;
  logic [2:0]  bcnt_r, bcnt_nxt;
  logic        init_r, init_nxt;
  logic        rs_r, rs_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [3:0]  held_nib_r, held_nib_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;

  logic        adv;
  logic        step_vld;
  out_item_t   step;
  logic        long_cmd;
  logic [12:0] nib_extra;
  logic [16:0] nib_sum;
  logic [16:0] byte_sum;

  assign adv      = !out_valid_r || pop;
  assign empty    = !out_valid_r;
  assign out_data = out_r;

  assign long_cmd  = !rs_r && (byte_r == CMD_CLEAR || byte_r == CMD_HOME);
  assign nib_extra = (nib_r == 3'd1) ? FIRST_NIBBLE_US : LATER_NIBBLE_US;
  assign nib_sum   = 17'(cfg.enable_pulse_us) + 17'(nib_extra);
  assign byte_sum  = 17'(cfg.enable_pulse_us) + 17'(cfg.byte_settle_us)
                   + (long_cmd ? 17'(cfg.long_command_us) : 17'd0);

  always_comb begin
    state_nxt = state_r;
    nib_nxt   = nib_r;
    sub_nxt   = sub_r;
    bcnt_nxt  = bcnt_r;
    init_nxt  = init_r;
    rs_nxt    = rs_r;
    byte_nxt  = byte_r;
    job_pop   = 1'b0;
    step_vld  = 1'b0;
    step      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          init_nxt  = job.is_init;
          rs_nxt    = job.rs;
          byte_nxt  = job.val;
          sub_nxt   = '0;
          bcnt_nxt  = '0;
          nib_nxt   = '0;
          state_nxt = job.is_init ? ST_POWER : ST_BYTE;
        end
      end
      ST_POWER: begin
        if (adv) begin
          step_vld     = 1'b1;
          step.wait_us = POWER_UP_US;
          state_nxt    = ST_NIB;
        end
      end
      ST_NIB: begin
        if (adv) begin
          // even steps raise EN, odd steps drop it
          step_vld          = 1'b1;
          step.enable_level = !nib_r[0];
          step.data_nibble  = (nib_r[2:1] == 2'd3) ? NIB_4BIT : NIB_WAKE;
          step.wait_us      = nib_r[0] ? sat16(nib_sum)
                                       : 16'(cfg.enable_pulse_us);
          nib_nxt = nib_r + 3'd1;
          if (nib_r == NIB_LAST) begin
            state_nxt = ST_BYTE;
            sub_nxt   = '0;
            bcnt_nxt  = '0;
            rs_nxt    = 1'b0;
            byte_nxt  = boot_cmd(3'd0);
          end
        end
      end
      ST_BYTE: begin
        if (adv) begin
          step_vld       = 1'b1;
          step.rs_level  = rs_r;
          unique case (sub_r)
            3'd0: begin
              step.data_nibble = held_nib_r;
              step.wait_us     = 16'(cfg.rs_setup_us);
            end
            3'd1: begin
              step.enable_level = 1'b1;
              step.data_nibble  = byte_r[7:4];
              step.wait_us      = 16'(cfg.enable_pulse_us);
            end
            3'd2: begin
              step.data_nibble = byte_r[7:4];
              step.wait_us     = 16'(cfg.enable_pulse_us);
            end
            3'd3: begin
              step.enable_level = 1'b1;
              step.data_nibble  = byte_r[3:0];
              step.wait_us      = 16'(cfg.enable_pulse_us);
            end
            default: begin
              step.data_nibble = byte_r[3:0];
              step.wait_us     = sat16(byte_sum);
            end
          endcase
          if (sub_r == SUB_LAST) begin
            sub_nxt = '0;
            if (init_r && bcnt_r != BOOT_LAST) begin
              bcnt_nxt = bcnt_r + 3'd1;
              byte_nxt = boot_cmd(bcnt_r + 3'd1);
            end else begin
              step.last = 1'b1;
              state_nxt = ST_IDLE;
            end
          end else begin
            sub_nxt = sub_r + 3'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    held_nib_nxt  = held_nib_r;
    if (adv) begin
      out_valid_nxt = step_vld;
      if (step_vld) begin
        out_nxt      = step;
        held_nib_nxt = step.data_nibble;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      nib_r       <= '0;
      sub_r       <= '0;
      bcnt_r      <= '0;
      init_r      <= 1'b0;
      rs_r        <= 1'b0;
      held_nib_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nib_r       <= nib_nxt;
      sub_r       <= sub_nxt;
      bcnt_r      <= bcnt_nxt;
      init_r      <= init_nxt;
      rs_r        <= rs_nxt;
      held_nib_r  <= held_nib_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ----- sv/char_lcd_4bit_write_sequencer.sv -----
// ----------------------------------------------------------------------------
// char_lcd_4bit_write_sequencer
// Character LCD 4-bit write sequencer: requests in, timed pin steps out.
// ----------------------------------------------------------------------------
// Path to first pin step: job queue, back-end job fetch, output register.
// Throughput: one step per cycle while pop keeps the output free; a byte
//   request is one job fetch and 5 steps, an initialise request one fetch
//   and 34 steps, set by the step sequencer in the back end.
// Reset: synchronous, active low; clears queue, sequencer and output stage,
//   loads config defaults. No clearing pass.
module char_lcd_4bit_write_sequencer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request side
  input  logic                  push,
  output logic                  full,
  input  lcdseq_pkg::in_item_t  in_data,
  // step side
  input  logic                  pop,
  output logic                  empty,
  output lcdseq_pkg::out_item_t out_data,
  // config port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import lcdseq_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  job_t front_job;
  job_t q_job;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic wr_en;

  // ---------------- config registers ----------------
  // pready tied high: every access completes in its access cycle
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_RS_SETUP: cfg_nxt.rs_setup_us     = pwdata[9:0];
        REG_EN_PULSE: cfg_nxt.enable_pulse_us = pwdata[9:0];
        REG_SETTLE:   cfg_nxt.byte_settle_us  = pwdata[13:0];
        REG_LONG_CMD: cfg_nxt.long_command_us = pwdata[13:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RS_SETUP: prdata = 32'(cfg_r.rs_setup_us);
      REG_EN_PULSE: prdata = 32'(cfg_r.enable_pulse_us);
      REG_SETTLE:   prdata = 32'(cfg_r.byte_settle_us);
      REG_LONG_CMD: prdata = 32'(cfg_r.long_command_us);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rs_setup_us     <= RST_RS_SETUP;
      cfg_r.enable_pulse_us <= RST_EN_PULSE;
      cfg_r.byte_settle_us  <= RST_SETTLE;
      cfg_r.long_command_us <= RST_LONG_CMD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------- front: classify request ----------------
  lcdseq_front u_front (
    .in_data (in_data),
    .job     (front_job)
  );

  // ---------------- job queue ----------------
  // full comes straight from the queue, so requests keep landing while
  // the back end is busy emitting steps.
  assign full = q_full;

  lcdseq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push && !q_full),
    .wr_job  (front_job),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_job  (q_job),
    .q_valid (q_valid)
  );

  // ---------------- back: step sequencer ----------------
  // One step per cycle into a single output register; a stalled pop
  // holds the step and freezes the sequencer.
  lcdseq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (q_valid),
    .job       (q_job),
    .job_pop   (q_pop),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data)
  );

endmodule

// ----- sv/lcdseq_checker.sv -----
// ----------------------------------------------------------------------------
// lcdseq_checker
// Port-level checks for the LCD write sequencer.
// ----------------------------------------------------------------------------
module lcdseq_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  full,
  input logic                  pop,
  input logic                  empty,
  input lcdseq_pkg::out_item_t out_data
);
  import lcdseq_pkg::*;

  // reset leaves no step pending
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("step pending after reset");

  // reset leaves the request queue open
  a_rst_not_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("full after reset");

  // a waiting step holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting step changed");

  // a request never ends with EN high
  a_last_en_low: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.last) |-> !out_data.enable_level)
    else $error("last step with enable high");

endmodule

bind char_lcd_4bit_write_sequencer lcdseq_checker u_lcdseq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .pop      (pop),
  .empty    (empty),
  .out_data (out_data)
);
